FILE: src/eep_depuncturer_assert.svh
// assertion macros shared by the checker
`ifndef EEP_DEPUNCTURER_ASSERT_SVH
`define EEP_DEPUNCTURER_ASSERT_SVH

// same-cycle implication
`define EEP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eep_depuncturer assertion failed");

// next-cycle implication
`define EEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eep_depuncturer assertion failed");

`endif

FILE: src/eep_pkg.sv
`default_nettype none

package eep_pkg;

  // widths
  localparam int DEF_SOFT_WIDTH = 8;
  localparam int BLOCK_WIDTH    = 12;
  localparam int POS_WIDTH      = 7;
  localparam int MASK_WIDTH     = 32;
  localparam int TAIL_WIDTH     = 24;
  localparam int SLOT_WIDTH     = 5;
  localparam int CNT_WIDTH      = 6;
  localparam int INDEX_WIDTH    = 3;
  localparam int CFG_WIDTH      = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_WIDTH     = 1;
  localparam int QCNT_WIDTH     = 2;

  // frame geometry
  localparam logic [POS_WIDTH:0]    BLOCK_POSITIONS = 8'd128;
  localparam logic [POS_WIDTH-1:0]  TAIL_POSITIONS  = 7'd24;
  localparam logic [SLOT_WIDTH-1:0] TAIL_LAST       = 5'd23;
  localparam logic [CNT_WIDTH-1:0]  CNT_MAX         = 6'd63;

  // register indexes
  localparam logic [INDEX_WIDTH-1:0] REG_FIRST_BLOCKS  = 3'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_SECOND_BLOCKS = 3'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_FIRST_MASK    = 3'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_SECOND_MASK   = 3'd3;
  localparam logic [INDEX_WIDTH-1:0] REG_TAIL_MASK     = 3'd4;

  // register reset values
  localparam logic [BLOCK_WIDTH-1:0] FIRST_BLOCKS_RST  = 12'd93;
  localparam logic [BLOCK_WIDTH-1:0] SECOND_BLOCKS_RST = 12'd3;
  localparam logic [MASK_WIDTH-1:0]  FIRST_MASK_RST    = 32'hFFFF_FFFF;
  localparam logic [MASK_WIDTH-1:0]  SECOND_MASK_RST   = 32'hFFFF_FFFF;
  localparam logic [TAIL_WIDTH-1:0]  TAIL_MASK_RST     = 24'h33_3333;

  typedef enum logic [1:0] {
    PART_FIRST,
    PART_SECOND,
    PART_TAIL
  } part_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WALK,
    MODE_TRAIL
  } mode_t;

  typedef struct packed {
    part_t                  part;
    logic [BLOCK_WIDTH-1:0] block_count;
    logic [POS_WIDTH-1:0]   position;
  } walk_state_t;

  typedef struct packed {
    logic [BLOCK_WIDTH-1:0] first_blocks;
    logic [BLOCK_WIDTH-1:0] second_blocks;
    logic [MASK_WIDTH-1:0]  first_mask;
    logic [MASK_WIDTH-1:0]  second_mask;
    logic [TAIL_WIDTH-1:0]  tail_mask;
    logic [SLOT_WIDTH-1:0]  last_slot;
  } cfg_t;

  localparam walk_state_t FRAME_START = '{part: PART_FIRST, block_count: '0, position: '0};

  // highest kept tail slot
  function automatic logic [SLOT_WIDTH-1:0] last_slot_of(logic [TAIL_WIDTH-1:0] mask);
    logic [SLOT_WIDTH-1:0] last;
    last = '0;
    for (int i = 0; i < TAIL_WIDTH; i++) begin
      if (mask[i]) begin
        last = SLOT_WIDTH'(i);
      end
    end
    return last;
  endfunction

  // skip parts whose block count is used up
  function automatic walk_state_t settle(walk_state_t s, cfg_t c);
    walk_state_t r;
    r = s;
    if (r.part == PART_FIRST && r.block_count >= c.first_blocks) begin
      r.part        = PART_SECOND;
      r.block_count = '0;
      r.position    = '0;
    end
    if (r.part == PART_SECOND && r.block_count >= c.second_blocks) begin
      r.part        = PART_TAIL;
      r.block_count = '0;
      r.position    = '0;
    end
    return r;
  endfunction

  // keep bit of the current position
  function automatic logic slot_kept(walk_state_t s, cfg_t c);
    logic                  kept;
    logic [MASK_WIDTH-1:0] tail_ext;
    tail_ext = {{(MASK_WIDTH - TAIL_WIDTH){1'b0}}, c.tail_mask};
    case (s.part)
      PART_FIRST:  kept = c.first_mask[s.position[SLOT_WIDTH-1:0]];
      PART_SECOND: kept = c.second_mask[s.position[SLOT_WIDTH-1:0]];
      default:     kept = (s.position < TAIL_POSITIONS) && tail_ext[s.position[SLOT_WIDTH-1:0]];
    endcase
    return kept;
  endfunction

  // step to the next position, wrapping blocks in the first two parts
  function automatic walk_state_t advance(walk_state_t s);
    walk_state_t          r;
    logic [POS_WIDTH-1:0] pos_inc;
    r       = s;
    pos_inc = s.position + 1'b1;
    r.position = pos_inc;
    if (s.part != PART_TAIL &&
        (pos_inc == '0 || {1'b0, pos_inc} >= BLOCK_POSITIONS)) begin
      r.position    = '0;
      r.block_count = s.block_count + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/eep_cfg_regs.sv
`default_nettype none

module eep_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [eep_pkg::INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [eep_pkg::CFG_WIDTH-1:0]     cfg_data,
  output eep_pkg::cfg_t                          cfg
);

  logic [eep_pkg::BLOCK_WIDTH-1:0] first_blocks;
  logic [eep_pkg::BLOCK_WIDTH-1:0] second_blocks;
  logic [eep_pkg::MASK_WIDTH-1:0]  first_mask;
  logic [eep_pkg::MASK_WIDTH-1:0]  second_mask;
  logic [eep_pkg::TAIL_WIDTH-1:0]  tail_mask;
  logic [eep_pkg::SLOT_WIDTH-1:0]  last_slot;

  // register writes, zero masks ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      first_blocks  <= eep_pkg::FIRST_BLOCKS_RST;
      second_blocks <= eep_pkg::SECOND_BLOCKS_RST;
      first_mask    <= eep_pkg::FIRST_MASK_RST;
      second_mask   <= eep_pkg::SECOND_MASK_RST;
      tail_mask     <= eep_pkg::TAIL_MASK_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        eep_pkg::REG_FIRST_BLOCKS: begin
          first_blocks <= cfg_data[eep_pkg::BLOCK_WIDTH-1:0];
        end
        eep_pkg::REG_SECOND_BLOCKS: begin
          second_blocks <= cfg_data[eep_pkg::BLOCK_WIDTH-1:0];
        end
        eep_pkg::REG_FIRST_MASK: begin
          if (cfg_data[eep_pkg::MASK_WIDTH-1:0] != '0) begin
            first_mask <= cfg_data[eep_pkg::MASK_WIDTH-1:0];
          end
        end
        eep_pkg::REG_SECOND_MASK: begin
          if (cfg_data[eep_pkg::MASK_WIDTH-1:0] != '0) begin
            second_mask <= cfg_data[eep_pkg::MASK_WIDTH-1:0];
          end
        end
        eep_pkg::REG_TAIL_MASK: begin
          if (cfg_data[eep_pkg::TAIL_WIDTH-1:0] != '0) begin
            tail_mask <= cfg_data[eep_pkg::TAIL_WIDTH-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // last kept tail slot of the current mask
  always_comb begin
    last_slot = eep_pkg::last_slot_of(tail_mask);
  end

  assign cfg = '{first_blocks:  first_blocks,
                 second_blocks: second_blocks,
                 first_mask:    first_mask,
                 second_mask:   second_mask,
                 tail_mask:     tail_mask,
                 last_slot:     last_slot};

endmodule

`default_nettype wire

FILE: src/eep_queue.sv
`default_nettype none

module eep_queue #(
  parameter int SOFT_WIDTH = eep_pkg::DEF_SOFT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SOFT_WIDTH-1:0] in_data,
  output logic                       q_valid,
  input  wire logic                  q_pop,
  output logic [SOFT_WIDTH-1:0]      q_data
);

  logic [SOFT_WIDTH-1:0]           entry [eep_pkg::QUEUE_DEPTH];
  logic [eep_pkg::QPTR_WIDTH-1:0]  wr_ptr;
  logic [eep_pkg::QPTR_WIDTH-1:0]  rd_ptr;
  logic [eep_pkg::QCNT_WIDTH-1:0]  count;
  logic                            push;
  logic                            pop;

  assign in_ready = (count != eep_pkg::QCNT_WIDTH'(eep_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_data   = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/eep_walker.sv
`default_nettype none

module eep_walker #(
  parameter int SOFT_WIDTH = eep_pkg::DEF_SOFT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire eep_pkg::cfg_t          cfg,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  input  wire logic [SOFT_WIDTH-1:0]  q_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [SOFT_WIDTH-1:0] soft_out,
  output logic                        is_erasure,
  output logic                        frame_end,
  output logic                        run_last
);

  eep_pkg::mode_t                  mode, mode_next;
  eep_pkg::walk_state_t            st, st_next;
  eep_pkg::walk_state_t            cur;
  eep_pkg::walk_state_t            prep;
  logic [SOFT_WIDTH-1:0]           value, value_next;
  logic [eep_pkg::CNT_WIDTH-1:0]   cnt, cnt_next;
  logic [eep_pkg::SLOT_WIDTH-1:0]  tail_pos, tail_pos_next;
  logic                            kept;
  logic                            at_last;
  logic                            can_emit;
  logic                            emit;
  logic [SOFT_WIDTH-1:0]           o_soft;
  logic                            o_er;
  logic                            o_fe;
  logic                            o_last;

  // settled position and its classification
  always_comb begin
    cur     = eep_pkg::settle(st, cfg);
    kept    = eep_pkg::slot_kept(cur, cfg);
    at_last = (cur.part == eep_pkg::PART_TAIL) &&
              (cur.position == {2'b00, cfg.last_slot});
    prep    = eep_pkg::settle(st, cfg);
    if (prep.part == eep_pkg::PART_TAIL && prep.position > {2'b00, cfg.last_slot}) begin
      prep = eep_pkg::FRAME_START;
    end
  end

  assign can_emit = !out_valid || out_ready;

  // sequencer: one result beat per cycle while walking or trailing and the output can take it
  always_comb begin
    mode_next     = mode;
    st_next       = st;
    value_next    = value;
    cnt_next      = cnt;
    tail_pos_next = tail_pos;
    q_pop         = 1'b0;
    emit          = 1'b0;
    o_soft        = '0;
    o_er          = 1'b0;
    o_fe          = 1'b0;
    o_last        = 1'b0;
    case (mode)
      eep_pkg::MODE_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          value_next = q_data;
          cnt_next   = '0;
          st_next    = prep;
          mode_next  = eep_pkg::MODE_WALK;
        end
      end
      eep_pkg::MODE_WALK: begin
        if (can_emit) begin
          emit = 1'b1;
          if (kept || cnt == eep_pkg::CNT_MAX) begin
            o_soft = value;
            if (at_last) begin
              o_fe    = (cfg.last_slot == eep_pkg::TAIL_LAST);
              o_last  = o_fe || (cnt == eep_pkg::CNT_MAX);
              st_next = eep_pkg::FRAME_START;
              if (o_last) begin
                mode_next = eep_pkg::MODE_IDLE;
              end else begin
                mode_next     = eep_pkg::MODE_TRAIL;
                tail_pos_next = cfg.last_slot + 1'b1;
                cnt_next      = cnt + 1'b1;
              end
            end else begin
              o_last    = 1'b1;
              st_next   = eep_pkg::advance(cur);
              mode_next = eep_pkg::MODE_IDLE;
            end
          end else begin
            o_er     = 1'b1;
            st_next  = eep_pkg::advance(cur);
            cnt_next = cnt + 1'b1;
          end
        end
      end
      eep_pkg::MODE_TRAIL: begin
        if (can_emit) begin
          emit          = 1'b1;
          o_er          = 1'b1;
          o_fe          = (tail_pos == eep_pkg::TAIL_LAST);
          o_last        = o_fe || (cnt == eep_pkg::CNT_MAX);
          cnt_next      = cnt + 1'b1;
          tail_pos_next = tail_pos + 1'b1;
          if (o_last) begin
            mode_next = eep_pkg::MODE_IDLE;
          end
        end
      end
      default: begin
        mode_next = eep_pkg::MODE_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= eep_pkg::MODE_IDLE;
      st   <= eep_pkg::FRAME_START;
    end else begin
      mode <= mode_next;
      st   <= st_next;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    value    <= value_next;
    cnt      <= cnt_next;
    tail_pos <= tail_pos_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      soft_out   <= o_soft;
      is_erasure <= o_er;
      frame_end  <= o_fe;
      run_last   <= o_last;
    end
  end

endmodule

`default_nettype wire

FILE: src/eep_depuncturer.sv
// an accepted item passes the input queue and the walker's working registers before its
// first result beat is registered; each item causes 1 to 64 result beats, and, unless the
// output stalls, the walker's single beat per cycle sets the rate; a 2-entry queue runs ahead
// reset: synchronous, active high; clears frame position, queue and output valid,
// and loads the register defaults; no clearing pass
`default_nettype none

module eep_depuncturer #(
  parameter int SOFT_WIDTH = eep_pkg::DEF_SOFT_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [eep_pkg::INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [eep_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [SOFT_WIDTH-1:0]     soft_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [SOFT_WIDTH-1:0]          soft_out,
  output logic                                  is_erasure,
  output logic                                  frame_end,
  output logic                                  run_last
);

  eep_pkg::cfg_t          cfg;
  logic                   q_valid;
  logic                   q_pop;
  logic [SOFT_WIDTH-1:0]  q_data;

  // configuration registers
  eep_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // front: input beats into a short queue
  eep_queue #(
    .SOFT_WIDTH (SOFT_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (soft_in),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  // back: position walker and output register
  eep_walker #(
    .SOFT_WIDTH (SOFT_WIDTH)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .soft_out   (soft_out),
    .is_erasure (is_erasure),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire

FILE: src/eep_checker.sv
`default_nettype none
`include "eep_depuncturer_assert.svh"

module eep_checker #(
  parameter int SOFT_WIDTH = eep_pkg::DEF_SOFT_WIDTH
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SOFT_WIDTH-1:0]  soft_out,
  input wire logic                   is_erasure,
  input wire logic                   frame_end,
  input wire logic                   run_last
);

  // a stalled beat stays valid
  `EEP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // erased positions carry zero
  `EEP_ASSERT_IMP(a_erasure_zero, clk, rst, out_valid && is_erasure, soft_out == '0)

  // the frame end always closes the run of its item
  `EEP_ASSERT_IMP(a_end_closes_run, clk, rst, out_valid && frame_end, run_last)

  // a stalled beat keeps its flags
  `EEP_ASSERT_NEXT(a_flags_stable, clk, rst, out_valid && !out_ready,
                   $stable(is_erasure) && $stable(frame_end) && $stable(run_last))

endmodule

bind eep_depuncturer eep_checker #(
  .SOFT_WIDTH (SOFT_WIDTH)
) u_eep_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .soft_out   (soft_out),
  .is_erasure (is_erasure),
  .frame_end  (frame_end),
  .run_last   (run_last)
);

`default_nettype wire

FILE: verif/eep_depuncturer_tb.sv
`timescale 1ns / 1ps

module testbench;
  import eep_pkg::*;

  localparam int SW           = DEF_SOFT_WIDTH;
  localparam int MAX_ERASE    = 63;
  localparam int MAX_BEATS    = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_ITEMS  = 40;

  localparam logic signed [SW-1:0] SOFT_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SOFT_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct packed {
    logic signed [SW-1:0] level;
    logic                 erasure;
    logic                 fend;
    logic                 run_last;
  } depunct_beat_t;

  // tracks frame position, predicts the position stream and checks it
  class depuncture_board;
    logic [BLOCK_WIDTH-1:0] first_blocks  = FIRST_BLOCKS_RST;
    logic [BLOCK_WIDTH-1:0] second_blocks = SECOND_BLOCKS_RST;
    logic [MASK_WIDTH-1:0]  first_mask    = FIRST_MASK_RST;
    logic [MASK_WIDTH-1:0]  second_mask   = SECOND_MASK_RST;
    logic [TAIL_WIDTH-1:0]  tail_mask     = TAIL_MASK_RST;

    part_t                  frame_part  = PART_FIRST;
    logic [BLOCK_WIDTH-1:0] blocks_done = '0;
    logic [POS_WIDTH-1:0]   pos         = '0;

    depunct_beat_t expected_beats[$];
    depunct_beat_t staged;
    bit            staged_ok = 1'b0;
    int            mismatches = 0;

    // register write, masks ignore all-zero data
    function void set_reg(logic [INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
      case (idx)
        REG_FIRST_BLOCKS:  first_blocks = data[BLOCK_WIDTH-1:0];
        REG_SECOND_BLOCKS: second_blocks = data[BLOCK_WIDTH-1:0];
        REG_FIRST_MASK:    if (data != '0) first_mask = data;
        REG_SECOND_MASK:   if (data != '0) second_mask = data;
        REG_TAIL_MASK:     if (data[TAIL_WIDTH-1:0] != '0) tail_mask = data[TAIL_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function void restart();
      frame_part  = PART_FIRST;
      blocks_done = '0;
      pos         = '0;
    endfunction

    // leave parts whose block count is used up
    function void skip_empty();
      if (frame_part == PART_FIRST && blocks_done >= first_blocks) begin
        frame_part  = PART_SECOND;
        blocks_done = '0;
        pos         = '0;
      end
      if (frame_part == PART_SECOND && blocks_done >= second_blocks) begin
        frame_part  = PART_TAIL;
        blocks_done = '0;
        pos         = '0;
      end
    endfunction

    function bit kept_here();
      case (frame_part)
        PART_FIRST:  return first_mask[pos[SLOT_WIDTH-1:0]];
        PART_SECOND: return second_mask[pos[SLOT_WIDTH-1:0]];
        default: begin
          if (pos < TAIL_WIDTH) return tail_mask[pos[SLOT_WIDTH-1:0]];
          return 1'b0;
        end
      endcase
    endfunction

    // next position, block wrap in the first two parts only
    function void step_pos();
      pos = pos + 1'b1;
      if (frame_part != PART_TAIL && pos == '0) blocks_done = blocks_done + 1'b1;
    endfunction

    function int top_tail_slot();
      int last_slot;
      last_slot = 0;
      for (int i = 0; i < TAIL_WIDTH; i++) if (tail_mask[i]) last_slot = i;
      return last_slot;
    endfunction

    // hold one beat back so the final one of a run can be flagged
    function void stage(logic signed [SW-1:0] v, logic er, logic fe);
      if (staged_ok) expected_beats.push_back(staged);
      staged    = '{level: v, erasure: er, fend: fe, run_last: 1'b0};
      staged_ok = 1'b1;
    endfunction

    // accepted input beat: erasures up to the next kept slot, then the value
    function void note_soft(logic signed [SW-1:0] value);
      int last_slot;
      int count;
      last_slot = top_tail_slot();
      count     = 0;
      skip_empty();
      if (frame_part == PART_TAIL && pos > last_slot) restart();
      skip_empty();
      while (!kept_here() && count < MAX_ERASE) begin
        stage('0, 1'b1, 1'b0);
        count++;
        step_pos();
        skip_empty();
      end
      if (frame_part == PART_TAIL && pos == last_slot) begin
        // last kept tail slot: flush the rest of the tail and close the frame
        stage(value, 1'b0, last_slot == TAIL_WIDTH - 1);
        count++;
        for (int p = last_slot + 1; p < TAIL_WIDTH && count < MAX_BEATS; p++) begin
          stage('0, 1'b1, p == TAIL_WIDTH - 1);
          count++;
        end
        restart();
      end else begin
        stage(value, 1'b0, 1'b0);
        step_pos();
      end
      staged.run_last = 1'b1;
      expected_beats.push_back(staged);
      staged_ok = 1'b0;
    endfunction

    function void check_beat(logic signed [SW-1:0] soft_val, logic er, logic fe, logic rl);
      depunct_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with none expected: soft_out %0d", soft_val);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      if (want.level !== soft_val) begin
        $error("soft_out expected %0d actual %0d", want.level, soft_val);
        mismatches++;
      end
      if (want.erasure !== er) begin
        $error("is_erasure expected %0b actual %0b", want.erasure, er);
        mismatches++;
      end
      if (want.fend !== fe) begin
        $error("frame_end expected %0b actual %0b", want.fend, fe);
        mismatches++;
      end
      if (want.run_last !== rl) begin
        $error("run_last expected %0b actual %0b", want.run_last, rl);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]   cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [SW-1:0]   soft_in;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [SW-1:0]   soft_out;
  logic                   is_erasure;
  logic                   frame_end;
  logic                   run_last;

  depuncture_board      board;
  logic signed [SW-1:0] soft_script[$];
  bit                   idle_on  = 1'b1;
  bit                   stall_on = 1'b1;

  eep_depuncturer i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .soft_in    (soft_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .soft_out   (soft_out),
    .is_erasure (is_erasure),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

  always #5 clk = ~clk;

  // sample beats mid-cycle, where inputs and outputs are stable
  always @(negedge clk) begin
    if (!rst && in_valid && in_ready) board.note_soft(soft_in);
    if (!rst && out_valid && out_ready) board.check_beat(soft_out, is_erasure, frame_end, run_last);
  end

  // receiver stalls in bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  // hang detection: no beat moving on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(logic [INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // sender with random gaps before beats
  task automatic send_script();
    logic signed [SW-1:0] v;
    while (soft_script.size() != 0) begin
      v = soft_script.pop_front();
      if (idle_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      in_valid <= 1'b1;
      soft_in  <= v;
      do @(negedge clk); while (!in_ready);
      @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // wait for every expected beat, then let the pipeline settle
  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_random(int n);
    repeat (n) soft_script.push_back(SW'($urandom));
  endfunction

  function automatic logic [CFG_WIDTH-1:0] reg_word(int r);
    logic [CFG_WIDTH-1:0] w;
    w = $urandom;
    case (r)
      REG_FIRST_BLOCKS, REG_SECOND_BLOCKS: begin
        // short frames mostly, now and then the largest count
        case ($urandom_range(0, 9))
          0:          w[BLOCK_WIDTH-1:0] = '1;
          1, 2, 3, 4: w[BLOCK_WIDTH-1:0] = '0;
          5, 6, 7, 8: w[BLOCK_WIDTH-1:0] = 1;
          default:    w[BLOCK_WIDTH-1:0] = 2;
        endcase
      end
      REG_TAIL_MASK: begin
        case ($urandom_range(0, 4))
          0:       w[TAIL_WIDTH-1:0] = '1;
          1:       w[TAIL_WIDTH-1:0] = TAIL_WIDTH'(1) << $urandom_range(0, TAIL_WIDTH - 1);
          2:       w[TAIL_WIDTH-1:0] = TAIL_WIDTH'(1) << (TAIL_WIDTH - 1);
          3:       w[TAIL_WIDTH-1:0] = TAIL_WIDTH'($urandom);
          default: w[TAIL_WIDTH-1:0] = TAIL_WIDTH'($urandom & $urandom);
        endcase
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       w = '1;
          1:       w = CFG_WIDTH'(1) << $urandom_range(0, MASK_WIDTH - 1);
          2:       w = $urandom;
          3:       w = $urandom & $urandom & $urandom;
          default: w = $urandom | $urandom;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic pick_config();
    for (int r = REG_FIRST_BLOCKS; r <= REG_TAIL_MASK; r++) begin
      if ($urandom_range(0, 3) != 0) write_reg(INDEX_WIDTH'(r), reg_word(r));
    end
    // writes that must leave the registers alone
    if ($urandom_range(0, 3) == 0)
      write_reg(INDEX_WIDTH'(REG_TAIL_MASK + 1 + $urandom_range(0, 2)), $urandom);
    if ($urandom_range(0, 4) == 0)
      write_reg(INDEX_WIDTH'(REG_FIRST_MASK + $urandom_range(0, 2)), '0);
  endtask

  initial begin
    int sent;
    int n;
    int phase;
    board     = new();
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    soft_in   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers, extremes of the soft value
    soft_script = '{SOFT_MIN, SOFT_MAX, '0};
    send_script();
    drain();

    // empty first and second parts, ignored writes, full tail
    write_reg(REG_FIRST_BLOCKS, 32'hFFFF_F000);
    write_reg(REG_SECOND_BLOCKS, 32'h0000_0000);
    write_reg(REG_FIRST_MASK, '0);
    write_reg(REG_SECOND_MASK, '0);
    write_reg(REG_TAIL_MASK, '0);
    write_reg(REG_TAIL_MASK, 32'hFF00_0000);
    for (int r = REG_TAIL_MASK + 1; r < (1 << INDEX_WIDTH); r++)
      write_reg(INDEX_WIDTH'(r), $urandom);
    write_reg(REG_TAIL_MASK, 32'h00FF_FFFF);
    queue_random(6);
    send_script();
    drain();

    // tail mask moved below the current tail position: frame restarts
    write_reg(REG_TAIL_MASK, 32'h0000_0010);
    queue_random(1);
    send_script();
    drain();

    // single-bit masks: erasure runs of up to 62 and a full tail flush
    write_reg(REG_FIRST_BLOCKS, 32'h0000_0001);
    write_reg(REG_SECOND_BLOCKS, 32'hABCD_E001);
    write_reg(REG_FIRST_MASK, 32'h0000_0001);
    write_reg(REG_SECOND_MASK, 32'h8000_0000);
    write_reg(REG_TAIL_MASK, 32'h0000_0001);
    queue_random(9);
    send_script();

    // random phases, each starting from an empty pipeline
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        idle_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      if (phase == 0) begin
        // largest counts and full masks
        write_reg(REG_FIRST_BLOCKS, 32'h0000_0FFF);
        write_reg(REG_SECOND_BLOCKS, 32'hFFFF_FFFF);
        write_reg(REG_FIRST_MASK, 32'hFFFF_FFFF);
        write_reg(REG_SECOND_MASK, 32'hFFFF_FFFF);
        write_reg(REG_TAIL_MASK, 32'h00FF_FFFF);
      end else begin
        pick_config();
      end
      n = $urandom_range(12, 36);
      queue_random(n);
      send_script();
      sent += n;
      phase++;
    end

    drain();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
